// ===== sv/lru_cache_prefetch_usage_assert.svh =====
`ifndef LRU_CACHE_PREFETCH_USAGE_ASSERT_SVH
`define LRU_CACHE_PREFETCH_USAGE_ASSERT_SVH
// Assert that an antecedent implies a consequent on the next edge.
`define LCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Assert that a condition holds at every edge out of reset.
`define LCP_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

// ===== sv/lcp_pkg.sv =====
package lcp_pkg;
   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;
   localparam int CAP_BITS = 7;
   localparam int CNT_BITS = 32;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   // controller to datapath commands
   typedef struct packed {
      logic lookup;   // register request, start tag compare
      logic apply;    // commit update from registered match
      logic clear;    // empty store and counters
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_clear;
   } sts_type;
endpackage

// ===== sv/lcp_ctrl.sv =====
module lcp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  lcp_pkg::sts_type  sts,
   output lcp_pkg::cmd_type  cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MATCH = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);

   // sequence one item: capture, match, apply, send
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.lookup = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: state_in = ST_APPLY;
         ST_APPLY: begin
            cmd.apply = 1'b1;
            cmd.clear = sts.is_clear;
            state_in = ST_SEND;
         end
         ST_SEND: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== sv/lcp_datapath.sv =====
module lcp_datapath #(
   parameter int ENTRIES   = 64,
   parameter int ADDR_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lcp_pkg::cmd_type                cmd,
   output lcp_pkg::sts_type                sts,
   input  logic [1:0]                      req_command,
   input  logic [ADDR_BITS-1:0]            req_address,
   input  logic [lcp_pkg::CAP_BITS-1:0]    capacity,
   output logic                            hit,
   output logic                            evicted,
   output logic [ADDR_BITS-1:0]            evicted_address,
   output logic                            evicted_unused,
   output logic [lcp_pkg::CAP_BITS-1:0]    occupancy,
   output logic [lcp_pkg::CNT_BITS-1:0]    miss_count,
   output logic [lcp_pkg::CNT_BITS-1:0]    wasted_count
);
   localparam int IW = $clog2(ENTRIES);
   localparam int FW = $clog2(ENTRIES + 1);
   localparam int OW = lcp_pkg::CAP_BITS;
   localparam int CW = lcp_pkg::CNT_BITS;

   logic [ADDR_BITS-1:0] tag_ff [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff, used_ff;
   logic [IW-1:0]        rank_ff [ENTRIES];
   logic [FW-1:0]        fill_ff;
   logic [CW-1:0]        miss_ff, waste_ff;
   logic [1:0]           cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   // registered match results
   logic [ENTRIES-1:0]   lruv_ff;
   logic                 hit_ff, full_ff;
   logic [IW-1:0]        hidx_ff, lidx_ff, fidx_ff;
   logic                 free_ff;

   logic [ENTRIES-1:0]   hitv, lruv;
   logic [IW-1:0]        hidx, lidx, fidx;
   logic                 anyfree;
   logic [FW-1:0]        effcap;

   assign sts.is_clear = (cmd_ff == lcp_pkg::CMD_CLEAR);

   // clamp capacity into 1..ENTRIES
   always_comb begin
      if (capacity == '0) effcap = FW'(1);
      else if (32'(capacity) > ENTRIES) effcap = FW'(ENTRIES);
      else effcap = FW'(capacity);
   end

   // parallel tag compare, LRU find (rank == fill-1), first free slot
   always_comb begin
      hidx = '0; lidx = '0; fidx = '0; anyfree = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         hitv[i] = valid_ff[i] && (tag_ff[i] == addr_ff);
         lruv[i] = valid_ff[i] && (FW'(rank_ff[i]) == fill_ff - FW'(1));
         if (hitv[i]) hidx = IW'(i);
         if (lruv[i]) lidx = IW'(i);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            fidx = IW'(i);
            anyfree = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
      end
      lruv_ff <= lruv;
      hit_ff  <= |hitv; hidx_ff <= hidx; lidx_ff <= lidx;
      fidx_ff <= fidx; free_ff <= anyfree;
      full_ff <= (fill_ff >= effcap) && (fill_ff != '0);
   end

   // apply the update for the registered item
   logic               rd, wr, rm, ev;
   logic [IW-1:0]      hrank;
   logic [IW-1:0]      slot;
   logic               ins;
   assign rd = (cmd_ff == lcp_pkg::CMD_READ);
   assign wr = (cmd_ff == lcp_pkg::CMD_WRITE);
   assign rm = (cmd_ff == lcp_pkg::CMD_REMOVE);
   assign ev = rd && !hit_ff && full_ff;
   assign hrank = rank_ff[hidx_ff];
   // after an eviction the freed slot is reused when no other slot was free
   assign slot = free_ff ? fidx_ff : lidx_ff;
   assign ins = rd && !hit_ff && (free_ff || ev);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0; used_ff <= '0; fill_ff <= '0;
         miss_ff <= '0; waste_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else if (cmd.apply) begin
         hit <= hit_ff && !cmd.clear;
         evicted <= ev;
         evicted_address <= ev ? tag_ff[lidx_ff] : '0;
         evicted_unused <= ev && !used_ff[lidx_ff];
         if (cmd.clear) begin
            valid_ff <= '0; used_ff <= '0; fill_ff <= '0;
            miss_ff <= '0; waste_ff <= '0;
            for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
            occupancy <= '0; miss_count <= '0; wasted_count <= '0;
         end else begin
            occupancy <= OW'(fill_ff - FW'(rm && hit_ff) + FW'(ins && !ev));
            miss_count <= (rd && !hit_ff && miss_ff != '1) ? miss_ff + 1'b1 : miss_ff;
            wasted_count <= (ev && !used_ff[lidx_ff] && waste_ff != '1)
                            ? waste_ff + 1'b1 : waste_ff;
            if (rd && !hit_ff && miss_ff != '1) miss_ff <= miss_ff + 1'b1;
            if (ev && !used_ff[lidx_ff] && waste_ff != '1) waste_ff <= waste_ff + 1'b1;
            if ((rd || wr) && hit_ff) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (valid_ff[i] && rank_ff[i] < hrank) rank_ff[i] <= rank_ff[i] + 1'b1;
               rank_ff[hidx_ff] <= '0;
               used_ff[hidx_ff] <= 1'b1;
            end else if (rm && hit_ff) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (valid_ff[i] && rank_ff[i] > hrank) rank_ff[i] <= rank_ff[i] - 1'b1;
               valid_ff[hidx_ff] <= 1'b0;
               used_ff[hidx_ff] <= 1'b0;
               rank_ff[hidx_ff] <= '0;
               fill_ff <= fill_ff - 1'b1;
            end else if (ins) begin
               // age everyone except the evicted entry, which holds the top rank
               for (int i = 0; i < ENTRIES; i++)
                  if (valid_ff[i] && !(ev && lruv_ff[i])) rank_ff[i] <= rank_ff[i] + 1'b1;
               if (ev) begin
                  valid_ff[lidx_ff] <= 1'b0;
                  used_ff[lidx_ff] <= 1'b0;
               end
               valid_ff[slot] <= 1'b1;
               used_ff[slot] <= 1'b0;
               rank_ff[slot] <= '0;
               tag_ff[slot] <= addr_ff;
               if (!ev) fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end
endmodule

// ===== sv/lru_cache_prefetch_usage.sv =====
// LRU cache of block addresses with a per-entry used mark.
// req channel: tdata = {address, command} (command in bits 1:0, address in 33:2),
//   commands read, write, remove, clear.
// rsp channel: one item per request with hit, eviction info, occupancy and
//   saturating miss and wasted-eviction counters.
// csr channel: writes the capacity register (7 bits, 0 acts as 1).
// Sequencing: the request is registered at capture, the tag match results are
//   registered in the match state and the response fields in the apply state,
//   after which the response is sent; one item is in flight at a time.
//   The steps are the controller's capture, tag match and update steps over
//   the flip-flop tag array.
// Reset empties the cache, zeroes counters and sets capacity to 64.
// When rsp_tready is low the response holds and no new request is taken.
module lru_cache_prefetch_usage #(
   parameter int ENTRIES   = 64,
   parameter int ADDR_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,  // command[1:0], address[33:2], zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,  // hit, evicted, evicted_address, evicted_unused,
                                    // occupancy, miss_count, wasted_count, zero
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);
   lcp_pkg::cmd_type cmd;
   lcp_pkg::sts_type sts;
   logic [6:0] cap_ff;
   logic hit, ev, evu;
   logic [ADDR_BITS-1:0] eva;
   logic [6:0] occ;
   logic [31:0] mc, wc;

   assign csr_ready = 1'b1;
   // hold the capacity register
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= lcp_pkg::CAP_RESET;
      else if (csr_valid) cap_ff <= csr_data;
   end

   lcp_ctrl u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid,
                    .rsp_tready, .sts, .cmd);

   lcp_datapath #(.ENTRIES(ENTRIES), .ADDR_BITS(ADDR_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_command(req_tdata[1:0]),
      .req_address(ADDR_BITS'(req_tdata[33:2])),
      .capacity(cap_ff),
      .hit, .evicted(ev), .evicted_address(eva), .evicted_unused(evu),
      .occupancy(occ), .miss_count(mc), .wasted_count(wc));

   assign rsp_tdata = {6'd0, wc, mc, occ, evu, 32'(eva), ev, hit};
endmodule

// ===== sv/lcp_checker.sv =====
`include "lru_cache_prefetch_usage_assert.svh"
module lcp_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [39:0]  req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata
);
   `LCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "response dropped while stalled")
   `LCP_ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid),
      "request taken while response pending")
   `LCP_ASSERT_ALWAYS(a_occ_range, clock, reset, !rsp_tvalid || rsp_tdata[41:35] <= 7'd64,
      "occupancy too large")
   `LCP_ASSERT_ALWAYS(a_ev_zero, clock, reset,
      !rsp_tvalid || rsp_tdata[1] || (rsp_tdata[33:2] == 32'd0 && !rsp_tdata[34]),
      "eviction fields set without eviction")
endmodule

bind lru_cache_prefetch_usage lcp_checker u_chk (.clock, .reset, .req_tvalid, .req_tready,
   .req_tdata, .rsp_tvalid, .rsp_tready, .rsp_tdata);
